// ===== rtl/core/btpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Types, codes and helpers shared by the compensation controller and datapath.
// ----------------------------------------------------------------------------
package btpc_pkg;

    typedef struct packed {
        logic        op;
        logic [23:0] raw_reading;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] value;
        logic        divide_error;
    } t_out_word;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } t_coef;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 48;
    localparam logic [CFG_AW-1:0] REG_AC123 = 3'd0;
    localparam logic [CFG_AW-1:0] REG_AC456 = 3'd1;
    localparam logic [CFG_AW-1:0] REG_B12   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MCMD  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_OSS   = 3'd4;

    localparam logic        KIND_TEMP  = 1'b0;
    localparam logic        KIND_PRESS = 1'b1;

    // datapath step codes
    localparam int OPW = 5;
    localparam logic [OPW-1:0] OP_NONE   = 5'd0;
    localparam logic [OPW-1:0] OP_LOAD   = 5'd1;
    localparam logic [OPW-1:0] OP_T_X1   = 5'd2;
    localparam logic [OPW-1:0] OP_T_DEN  = 5'd3;
    localparam logic [OPW-1:0] OP_DIV    = 5'd4;
    localparam logic [OPW-1:0] OP_T_FIN  = 5'd5;
    localparam logic [OPW-1:0] OP_P_B6   = 5'd6;
    localparam logic [OPW-1:0] OP_P_SQ   = 5'd7;
    localparam logic [OPW-1:0] OP_P_X1A  = 5'd8;
    localparam logic [OPW-1:0] OP_P_X2A  = 5'd9;
    localparam logic [OPW-1:0] OP_P_B3   = 5'd10;
    localparam logic [OPW-1:0] OP_P_Y1   = 5'd11;
    localparam logic [OPW-1:0] OP_P_Y2   = 5'd12;
    localparam logic [OPW-1:0] OP_P_X3   = 5'd13;
    localparam logic [OPW-1:0] OP_P_B4   = 5'd14;
    localparam logic [OPW-1:0] OP_P_B7   = 5'd15;
    localparam logic [OPW-1:0] OP_P_DIVS = 5'd16;
    localparam logic [OPW-1:0] OP_P_PQ   = 5'd17;
    localparam logic [OPW-1:0] OP_P_M1   = 5'd18;
    localparam logic [OPW-1:0] OP_P_M2   = 5'd19;
    localparam logic [OPW-1:0] OP_P_M3   = 5'd20;
    localparam logic [OPW-1:0] OP_P_FIN  = 5'd21;
    localparam logic [OPW-1:0] OP_ERR    = 5'd22;

    localparam logic [31:0] C_4000  = 32'd4000;
    localparam logic [31:0] C_3038  = 32'd3038;
    localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
    localparam logic [31:0] C_3791  = 32'd3791;
    localparam logic [31:0] C_32768 = 32'd32768;
    localparam logic [15:0] C_50000 = 16'd50000;

    typedef struct packed {
        logic [OPW-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic is_press;
        logic zero;
        logic div_done;
    } t_status;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] sh);
        return 32'($signed(v) >>> sh);
    endfunction

endpackage

// ===== rtl/core/baro_temp_pressure_compensation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// Barometric sensor compensation: temperature (0.1 degC) and pressure (Pa).
// ----------------------------------------------------------------------------
// One word at a time. A temperature or pressure word steps from accept to
// result valid through the radix-2 divider and through the single shared
// 32x32 multiplier. A zero divisor ends early with value 0 and the error
// flag. The input stalls from accept until the result word is taken.
// Coefficients must be written only while idle; the block does not enforce it.
module baro_temp_pressure_compensation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  btpc_pkg::t_in_word                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output btpc_pkg::t_out_word               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [btpc_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [btpc_pkg::CFG_DW-1:0]       i_cfg_data
);

    btpc_pkg::t_coef   r_coef;
    btpc_pkg::t_cmd    w_cmd;
    btpc_pkg::t_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                btpc_pkg::REG_AC123: begin
                    r_coef.ac1 <= i_cfg_data[47:32];
                    r_coef.ac2 <= i_cfg_data[31:16];
                    r_coef.ac3 <= i_cfg_data[15:0];
                end
                btpc_pkg::REG_AC456: begin
                    r_coef.ac4 <= i_cfg_data[47:32];
                    r_coef.ac5 <= i_cfg_data[31:16];
                    r_coef.ac6 <= i_cfg_data[15:0];
                end
                btpc_pkg::REG_B12: begin
                    r_coef.b1 <= i_cfg_data[31:16];
                    r_coef.b2 <= i_cfg_data[15:0];
                end
                btpc_pkg::REG_MCMD: begin
                    r_coef.mc <= i_cfg_data[31:16];
                    r_coef.md <= i_cfg_data[15:0];
                end
                btpc_pkg::REG_OSS: r_coef.oss <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    btpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    btpc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .i_coef     (r_coef),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while input open");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid))
        else $error("accept did not start work");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result repeated");

endmodule

// ===== rtl/core/btpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_ctrl
// Sequencer: steps the datapath through the temperature or pressure recipe.
// ----------------------------------------------------------------------------
module btpc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    input  btpc_pkg::t_status  i_status,
    output btpc_pkg::t_cmd     o_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid
);

    localparam logic [btpc_pkg::OPW-1:0] S_IDLE = btpc_pkg::OP_NONE;
    localparam logic [btpc_pkg::OPW-1:0] S_DONE = 5'd31;

    logic [btpc_pkg::OPW-1:0] r_state;
    logic [btpc_pkg::OPW-1:0] n_state;
    logic                     w_accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        if (r_state == S_IDLE) begin
            o_cmd.op = w_accept ? btpc_pkg::OP_LOAD : btpc_pkg::OP_NONE;
        end else if (r_state == S_DONE || r_state == btpc_pkg::OP_LOAD) begin
            o_cmd.op = btpc_pkg::OP_NONE;
        end else begin
            o_cmd.op = r_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = btpc_pkg::OP_LOAD;
                end
            end
            btpc_pkg::OP_LOAD:
                n_state = i_status.is_press ? btpc_pkg::OP_P_B6 : btpc_pkg::OP_T_X1;
            btpc_pkg::OP_T_X1:  n_state = btpc_pkg::OP_T_DEN;
            btpc_pkg::OP_T_DEN:
                n_state = i_status.zero ? btpc_pkg::OP_ERR : btpc_pkg::OP_DIV;
            btpc_pkg::OP_DIV: begin
                if (i_status.div_done) begin
                    n_state = i_status.is_press ? btpc_pkg::OP_P_PQ : btpc_pkg::OP_T_FIN;
                end
            end
            btpc_pkg::OP_T_FIN:  n_state = S_DONE;
            btpc_pkg::OP_P_B6:   n_state = btpc_pkg::OP_P_SQ;
            btpc_pkg::OP_P_SQ:   n_state = btpc_pkg::OP_P_X1A;
            btpc_pkg::OP_P_X1A:  n_state = btpc_pkg::OP_P_X2A;
            btpc_pkg::OP_P_X2A:  n_state = btpc_pkg::OP_P_B3;
            btpc_pkg::OP_P_B3:   n_state = btpc_pkg::OP_P_Y1;
            btpc_pkg::OP_P_Y1:   n_state = btpc_pkg::OP_P_Y2;
            btpc_pkg::OP_P_Y2:   n_state = btpc_pkg::OP_P_X3;
            btpc_pkg::OP_P_X3:   n_state = btpc_pkg::OP_P_B4;
            btpc_pkg::OP_P_B4:   n_state = btpc_pkg::OP_P_B7;
            btpc_pkg::OP_P_B7:
                n_state = i_status.zero ? btpc_pkg::OP_ERR : btpc_pkg::OP_P_DIVS;
            btpc_pkg::OP_P_DIVS: n_state = btpc_pkg::OP_DIV;
            btpc_pkg::OP_P_PQ:   n_state = btpc_pkg::OP_P_M1;
            btpc_pkg::OP_P_M1:   n_state = btpc_pkg::OP_P_M2;
            btpc_pkg::OP_P_M2:   n_state = btpc_pkg::OP_P_M3;
            btpc_pkg::OP_P_M3:   n_state = btpc_pkg::OP_P_FIN;
            btpc_pkg::OP_P_FIN:  n_state = S_DONE;
            btpc_pkg::OP_ERR:    n_state = S_DONE;
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default:             n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/btpc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_dp
// Datapath: shared 32x32 multiplier, radix-2 divider and working registers.
// ----------------------------------------------------------------------------
module btpc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btpc_pkg::t_cmd      i_cmd,
    input  btpc_pkg::t_in_word  i_in_data,
    input  btpc_pkg::t_coef     i_coef,
    output btpc_pkg::t_status   o_status,
    output btpc_pkg::t_out_word o_out_data
);

    logic        r_op;
    logic [23:0] r_raw;
    logic [31:0] r_b5, r_x1, r_b6, r_sq, r_t1, r_t2, r_b3, r_b4, r_b7, r_p;
    logic [31:0] r_rem, r_quo, r_dvs;
    logic [5:0]  r_cnt;
    logic        r_neg, r_shl;
    logic        r_kind, r_err;
    logic [31:0] r_val;

    logic [31:0] w_ma, w_mb, w_prod, w_den, w_dvd, w_q, w_b5, w_up, w_s8;
    logic [32:0] w_sh;
    logic        w_ge;

    assign w_den = r_x1 + btpc_pkg::sx16(i_coef.md);
    assign w_dvd = btpc_pkg::sx16(i_coef.mc) << 11;
    assign w_q   = r_neg ? (32'd0 - r_quo) : r_quo;
    assign w_b5  = r_x1 + w_q;
    assign w_up  = {8'd0, r_raw >> (4'd8 - {2'd0, i_coef.oss})};
    assign w_s8  = btpc_pkg::sra32(r_p, 5'd8);
    assign w_sh  = {r_rem, r_quo[31]};
    assign w_ge  = (w_sh >= {1'b0, r_dvs});

    always_comb begin
        w_ma = r_b6;
        w_mb = r_b6;
        case (i_cmd.op)
            btpc_pkg::OP_T_X1: begin
                w_ma = {16'd0, r_raw[15:0]} - {16'd0, i_coef.ac6};
                w_mb = {16'd0, i_coef.ac5};
            end
            btpc_pkg::OP_P_X1A: begin
                w_ma = btpc_pkg::sx16(i_coef.b2);
                w_mb = r_sq;
            end
            btpc_pkg::OP_P_X2A: w_ma = btpc_pkg::sx16(i_coef.ac2);
            btpc_pkg::OP_P_Y1:  w_ma = btpc_pkg::sx16(i_coef.ac3);
            btpc_pkg::OP_P_Y2: begin
                w_ma = btpc_pkg::sx16(i_coef.b1);
                w_mb = r_sq;
            end
            btpc_pkg::OP_P_B4: begin
                w_ma = {16'd0, i_coef.ac4};
                w_mb = r_t1 + btpc_pkg::C_32768;
            end
            btpc_pkg::OP_P_B7: begin
                w_ma = w_up - r_b3;
                w_mb = {16'd0, btpc_pkg::C_50000 >> i_coef.oss};
            end
            btpc_pkg::OP_P_M1: begin
                w_ma = w_s8;
                w_mb = w_s8;
            end
            btpc_pkg::OP_P_M2: begin
                w_ma = r_t1;
                w_mb = btpc_pkg::C_3038;
            end
            btpc_pkg::OP_P_M3: begin
                w_ma = btpc_pkg::C_M7357;
                w_mb = r_p;
            end
            default: begin
                w_ma = r_b6;
                w_mb = r_b6;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign o_status.is_press = r_op;
    assign o_status.zero     = r_op ? (r_b4 == 32'd0) : (w_den == 32'd0);
    assign o_status.div_done = (r_cnt == 6'd0);

    assign o_out_data.result_kind  = r_kind;
    assign o_out_data.value        = r_val;
    assign o_out_data.divide_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b5  <= 32'd0;
            r_cnt <= 6'd0;
        end else begin
            case (i_cmd.op)
                btpc_pkg::OP_LOAD: begin
                    r_op  <= i_in_data.op;
                    r_raw <= i_in_data.raw_reading;
                end
                btpc_pkg::OP_T_X1: r_x1 <= btpc_pkg::sra32(w_prod, 5'd15);
                btpc_pkg::OP_T_DEN: begin
                    r_neg <= w_dvd[31] ^ w_den[31];
                    r_quo <= w_dvd[31] ? (32'd0 - w_dvd) : w_dvd;
                    r_dvs <= w_den[31] ? (32'd0 - w_den) : w_den;
                    r_rem <= 32'd0;
                    r_cnt <= 6'd32;
                end
                btpc_pkg::OP_DIV: begin
                    if (r_cnt != 6'd0) begin
                        r_cnt <= r_cnt - 6'd1;
                        if (w_ge) begin
                            r_rem <= 32'(w_sh - {1'b0, r_dvs});
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= w_sh[31:0];
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                    end
                end
                btpc_pkg::OP_T_FIN: begin
                    r_b5   <= w_b5;
                    r_kind <= btpc_pkg::KIND_TEMP;
                    r_val  <= btpc_pkg::sra32(w_b5 + 32'd8, 5'd4);
                    r_err  <= 1'b0;
                end
                btpc_pkg::OP_P_B6:  r_b6 <= r_b5 - btpc_pkg::C_4000;
                btpc_pkg::OP_P_SQ:  r_sq <= btpc_pkg::sra32(w_prod, 5'd12);
                btpc_pkg::OP_P_X1A: r_t1 <= btpc_pkg::sra32(w_prod, 5'd11);
                btpc_pkg::OP_P_X2A: r_t2 <= btpc_pkg::sra32(w_prod, 5'd11);
                btpc_pkg::OP_P_B3:
                    r_b3 <= btpc_pkg::sra32((((btpc_pkg::sx16(i_coef.ac1) << 2) + r_t1 + r_t2)
                                             << i_coef.oss) + 32'd2, 5'd2);
                btpc_pkg::OP_P_Y1:  r_t1 <= btpc_pkg::sra32(w_prod, 5'd13);
                btpc_pkg::OP_P_Y2:  r_t2 <= btpc_pkg::sra32(w_prod, 5'd16);
                btpc_pkg::OP_P_X3:  r_t1 <= btpc_pkg::sra32(r_t1 + r_t2 + 32'd2, 5'd2);
                btpc_pkg::OP_P_B4:  r_b4 <= w_prod >> 15;
                btpc_pkg::OP_P_B7:  r_b7 <= w_prod;
                btpc_pkg::OP_P_DIVS: begin
                    r_shl <= r_b7[31];
                    r_neg <= 1'b0;
                    r_quo <= r_b7[31] ? r_b7 : (r_b7 << 1);
                    r_dvs <= r_b4;
                    r_rem <= 32'd0;
                    r_cnt <= 6'd32;
                end
                btpc_pkg::OP_P_PQ:  r_p  <= r_shl ? (r_quo << 1) : r_quo;
                btpc_pkg::OP_P_M1:  r_t1 <= w_prod;
                btpc_pkg::OP_P_M2:  r_t1 <= btpc_pkg::sra32(w_prod, 5'd16);
                btpc_pkg::OP_P_M3:  r_t2 <= btpc_pkg::sra32(w_prod, 5'd16);
                btpc_pkg::OP_P_FIN: begin
                    r_kind <= btpc_pkg::KIND_PRESS;
                    r_val  <= r_p + btpc_pkg::sra32(r_t1 + r_t2 + btpc_pkg::C_3791, 5'd4);
                    r_err  <= 1'b0;
                end
                btpc_pkg::OP_ERR: begin
                    r_kind <= r_op;
                    r_val  <= 32'd0;
                    r_err  <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
